/* src/srq_pkg.sv */
package srq_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned FaultW = 5;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [TimeW-1:0] time_word_t;
  typedef logic [FaultW-1:0] fault_mask_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    HEALTH_VALID    = 2'd0,
    HEALTH_DEGRADED = 2'd1,
    HEALTH_FAILED   = 2'd2
  } health_t;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INVERT_LEVEL   = 3'd0,
    REG_DEBOUNCE_TIME  = 3'd1,
    REG_MIN_PRESS_TIME = 3'd2,
    REG_MAX_PRESS_TIME = 3'd3,
    REG_STUCK_TIME     = 3'd4
  } reg_idx_t;

  localparam fault_mask_t FAULT_COMM     = 5'h01;
  localparam fault_mask_t FAULT_DEBOUNCE = 5'h02;
  localparam fault_mask_t FAULT_STARTUP  = 5'h04;
  localparam fault_mask_t FAULT_PLAUS    = 5'h08;
  localparam fault_mask_t FAULT_STUCK    = 5'h10;
  localparam fault_mask_t FAULT_NONE     = 5'h00;

  typedef struct packed {
    logic       op;
    logic       pin_level;
    logic       sample_ok;
    time_word_t event_time;
  } item_t;

  typedef struct packed {
    logic        state_active;
    logic        state_armed;
    logic [1:0]  state_health;
    fault_mask_t state_faults;
    time_word_t  state_time;
    logic        shift_req;
    time_word_t  request_start;
    time_word_t  request_end;
    time_word_t  request_duration;
  } result_t;

  typedef struct packed {
    logic       invert_level;
    time_word_t debounce_time;
    time_word_t min_press_time;
    time_word_t max_press_time;
    time_word_t stuck_time;
  } cfg_t;

  typedef struct packed {
    logic        started;
    time_word_t  last_edge_time;
    time_word_t  active_start;
    logic        armed_flag;
    logic        pending_check;
    logic        saved_active;
    logic        saved_armed;
    health_t     saved_health;
    fault_mask_t saved_faults;
    time_word_t  saved_time;
  } qual_state_t;

endpackage

/* src/shift_request_input_qualifier.sv */
// Shift-request input qualifier.
// Input channel item_valid/item_ready/item_word carries one word per edge
// event (op edge) or stuck-check tick (op tick); output channel
// res_valid/res_ready/res_word returns exactly one result word per input.
// Configuration registers are written through cfg_we/cfg_index/cfg_data,
// one register per cycle. The user must write them only while no word is
// in flight; the block itself does not enforce this. A word accepted into
// the input register is evaluated against the qualifier state and lands
// in the result register when it advances; res_valid then holds until taken.
// Throughput: one word per cycle when unstalled. The state update is a single pass of
// compares and 32-bit subtractions between the input and result registers.
// Receiver stall: the result register holds its word; the input register
// holds one more, and item_ready drops only when both are full.
// Reset (rst, synchronous): both registers empty, qualifier state cleared
// (not started, not armed, healthy), all configuration registers zero.
module shift_request_input_qualifier (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  srq_pkg::item_t      item_word,
  output logic                res_valid,
  input  logic                res_ready,
  output srq_pkg::result_t    res_word,
  input  logic                cfg_we,
  input  srq_pkg::cfg_idx_t   cfg_index,
  input  srq_pkg::time_word_t cfg_data
);

  srq_pkg::cfg_t        cfg;
  srq_pkg::qual_state_t st;
  srq_pkg::qual_state_t st_next;
  srq_pkg::result_t     eval_result;
  srq_pkg::item_t       stg_item;
  logic                 stg_valid;
  logic                 advance;

  srq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srq_eval u_eval (
    .cfg     (cfg),
    .st      (st),
    .item    (stg_item),
    .st_next (st_next),
    .result  (eval_result)
  );

  assign advance = stg_valid && (!res_valid || res_ready);
  assign item_ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      res_valid <= 1'b0;
      st <= '0;
    end else begin
      if (item_ready) begin
        stg_valid <= item_valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
        st <= st_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stg_item <= item_word;
    end
    if (advance) begin
      res_word <= eval_result;
    end
  end

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("result register not loaded after advance");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && res_valid && !res_ready) |=> (stg_valid && $stable(stg_item)))
    else $error("staged word lost during stall");

  a_idle_before_start: assert property (@(posedge clk) disable iff (rst)
    !st.started |-> (st.active_start == '0 && !st.armed_flag && !st.pending_check))
    else $error("press state set before first edge");

  a_edge_starts: assert property (@(posedge clk) disable iff (rst)
    (advance && stg_item.op == srq_pkg::OP_EDGE) |=> st.started)
    else $error("edge did not start qualifier");

  a_request_healthy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.shift_req) |->
      (res_word.state_health == srq_pkg::HEALTH_VALID &&
       res_word.state_faults == srq_pkg::FAULT_NONE))
    else $error("request issued with faulted state");

endmodule

/* src/srq_cfg.sv */
module srq_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  srq_pkg::cfg_idx_t    cfg_index,
  input  srq_pkg::time_word_t  cfg_data,
  output srq_pkg::cfg_t        cfg
);

  srq_pkg::cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      case (cfg_index)
        srq_pkg::REG_INVERT_LEVEL:   cfg_next.invert_level = cfg_data[0];
        srq_pkg::REG_DEBOUNCE_TIME:  cfg_next.debounce_time = cfg_data;
        srq_pkg::REG_MIN_PRESS_TIME: cfg_next.min_press_time = cfg_data;
        srq_pkg::REG_MAX_PRESS_TIME: cfg_next.max_press_time = cfg_data;
        srq_pkg::REG_STUCK_TIME:     cfg_next.stuck_time = cfg_data;
        default:                     cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

/* src/srq_eval.sv */
module srq_eval (
  input  srq_pkg::cfg_t        cfg,
  input  srq_pkg::qual_state_t st,
  input  srq_pkg::item_t       item,
  output srq_pkg::qual_state_t st_next,
  output srq_pkg::result_t     result
);

  logic                  act;
  logic                  checks_on;
  srq_pkg::time_word_t   since_active;
  srq_pkg::time_word_t   since_edge;
  srq_pkg::time_word_t   dur;
  srq_pkg::fault_mask_t  extra;
  logic                  req;
  srq_pkg::time_word_t   req_start;
  srq_pkg::time_word_t   req_end;
  srq_pkg::time_word_t   req_dur;

  assign act = item.pin_level ^ cfg.invert_level;
  assign checks_on = (cfg.min_press_time != '0) || (cfg.max_press_time != '0);
  assign since_active = item.event_time - st.active_start;
  assign since_edge = item.event_time - st.last_edge_time;
  assign dur = (st.active_start != '0 && item.event_time >= st.active_start) ?
               since_active : '0;

  always_comb begin
    st_next = st;
    extra = srq_pkg::FAULT_NONE;
    req = 1'b0;
    req_start = '0;
    req_end = '0;
    req_dur = '0;
    if (item.op == srq_pkg::OP_TICK) begin
      if (st.saved_active && st.active_start != '0 && since_active > cfg.stuck_time) begin
        st_next.saved_time = item.event_time;
        st_next.saved_active = 1'b1;
        st_next.saved_armed = 1'b0;
        st_next.saved_health = srq_pkg::HEALTH_FAILED;
        st_next.saved_faults = srq_pkg::FAULT_STUCK;
      end
    end else if (!st.started) begin
      // first edge: sample status ignored, an active switch is a startup fault
      st_next.started = 1'b1;
      st_next.last_edge_time = item.event_time;
      st_next.active_start = act ? item.event_time : '0;
      st_next.armed_flag = !act;
      st_next.saved_time = item.event_time;
      st_next.saved_active = act;
      st_next.saved_armed = !act;
      if (act) begin
        st_next.saved_health = srq_pkg::HEALTH_FAILED;
        st_next.saved_faults = srq_pkg::FAULT_STARTUP;
      end else begin
        st_next.saved_health = srq_pkg::HEALTH_VALID;
        st_next.saved_faults = srq_pkg::FAULT_NONE;
      end
    end else if (!item.sample_ok) begin
      st_next.saved_time = item.event_time;
      st_next.saved_active = act;
      st_next.saved_armed = 1'b0;
      st_next.saved_health = srq_pkg::HEALTH_FAILED;
      st_next.saved_faults = srq_pkg::FAULT_COMM;
    end else if (since_edge < cfg.debounce_time) begin
      extra = srq_pkg::FAULT_DEBOUNCE;
    end else if (!act) begin
      // release
      st_next.last_edge_time = item.event_time;
      st_next.armed_flag = 1'b1;
      st_next.active_start = '0;
      st_next.pending_check = 1'b0;
      st_next.saved_time = item.event_time;
      st_next.saved_active = 1'b0;
      st_next.saved_armed = 1'b1;
      st_next.saved_health = srq_pkg::HEALTH_VALID;
      st_next.saved_faults = srq_pkg::FAULT_NONE;
      if (st.pending_check) begin
        if (cfg.min_press_time != '0 && dur < cfg.min_press_time) begin
          st_next.saved_health = srq_pkg::HEALTH_DEGRADED;
          st_next.saved_faults = srq_pkg::FAULT_PLAUS;
        end else if (cfg.max_press_time != '0 && dur > cfg.max_press_time) begin
          st_next.saved_health = srq_pkg::HEALTH_FAILED;
          st_next.saved_faults = srq_pkg::FAULT_STUCK;
        end else begin
          req = 1'b1;
          req_start = st.active_start;
          req_end = item.event_time;
          req_dur = dur;
        end
      end
    end else begin
      // press
      st_next.last_edge_time = item.event_time;
      st_next.active_start = item.event_time;
      if (st.armed_flag) begin
        st_next.armed_flag = 1'b0;
        if (checks_on) begin
          st_next.pending_check = 1'b1;
        end else begin
          req = 1'b1;
          req_start = item.event_time;
        end
      end
      st_next.saved_time = item.event_time;
      st_next.saved_active = 1'b1;
      st_next.saved_armed = st_next.armed_flag;
      st_next.saved_health = srq_pkg::HEALTH_VALID;
      st_next.saved_faults = srq_pkg::FAULT_NONE;
    end
  end

  always_comb begin
    result.state_active = st_next.saved_active;
    result.state_armed = st_next.saved_armed;
    result.state_health = st_next.saved_health;
    result.state_faults = st_next.saved_faults | extra;
    result.state_time = st_next.saved_time;
    result.shift_req = req;
    result.request_start = req_start;
    result.request_end = req_end;
    result.request_duration = req_dur;
  end

endmodule
